// ===== sv/dltq_pkg.sv =====
package dltq_pkg;

	// request kinds
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	// result event codes
	localparam logic [2:0] EV_STARTED   = 3'd0;
	localparam logic [2:0] EV_CANCELLED = 3'd1;
	localparam logic [2:0] EV_IGNORED   = 3'd2;
	localparam logic [2:0] EV_EXPIRED   = 3'd3;
	localparam logic [2:0] EV_NONE      = 3'd4;

	// most expiries one tick reports
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W = 5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  timer_id;
		logic [31:0] timeout;
		logic [31:0] elapsed;
	} req_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [3:0] which_timer;
		logic       last;
	} rsp_item_t;

endpackage

// ===== sv/dltq_req_if.sv =====
interface dltq_req_if import dltq_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/dltq_rsp_if.sv =====
interface dltq_rsp_if import dltq_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/delta_list_timer_queue.sv =====
// One-shot timer queue for NUM_TIMERS slots, kept as a doubly linked delta
// list in one synchronous memory indexed by slot (previous, next, delta),
// with head, tail, count and per-slot pending bits in flip-flops. One
// request is handled at a time; results leave through an output register,
// so the next request is taken while a result still waits. An ignored or
// unused request ends at decode. A start walks the list one entry per cycle
// on the memory read port, after first unlinking the slot when restarting
// an active one. A tick reports one result per expired timer, at most
// MAX_RESULTS. Output stalls hold the states that push a result.
module delta_list_timer_queue import dltq_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	dltq_req_if.sink  req,
	dltq_rsp_if.source rsp
);

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int TW = TIME_WIDTH;

	typedef struct packed {
		logic [IW-1:0] prv;
		logic [IW-1:0] nxt;
		logic [TW-1:0] dlt;
	} entry_t;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_K1    = 4'd2;
	localparam logic [3:0] S_K2    = 4'd3;
	localparam logic [3:0] S_K3    = 4'd4;
	localparam logic [3:0] S_CFIN  = 4'd5;
	localparam logic [3:0] S_INS0  = 4'd6;
	localparam logic [3:0] S_IW    = 4'd7;
	localparam logic [3:0] S_INEW  = 4'd8;
	localparam logic [3:0] S_IPRED = 4'd9;
	localparam logic [3:0] S_ITAIL = 4'd10;
	localparam logic [3:0] S_IFIN  = 4'd11;
	localparam logic [3:0] S_TEV   = 4'd12;

	logic [3:0] state_q;

	// latched request
	logic [1:0]    kind_q;
	logic [3:0]    id_q;
	logic [TW-1:0] tmo_q;
	logic [TW-1:0] el_q;

	// list control
	logic [IW-1:0]       head_q, tail_q;
	logic [CW-1:0]       count_q;
	logic [NUM_TIMERS-1:0] pending_q;

	// walk registers
	logic [IW-1:0] cur_q, pred_q;
	entry_t        pred_e_q, ce_q;
	logic [TW-1:0] prev_q, dn_q;
	logic [CW-1:0] i_q;
	logic [NRES_W-1:0] n_q;
	logic          held_q;
	logic [IW-1:0] held_id_q;

	// list memory
	entry_t        mem [NUM_TIMERS];
	entry_t        rd_q;
	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	entry_t        wr_data;

	// output register
	rsp_item_t out_q;
	logic      out_valid_q;
	logic      out_free, push;
	rsp_item_t push_d;

	logic [IW-1:0] slot;
	logic          id_ok, pend;
	logic [TW:0]   total;
	logic          hit, stop;
	logic [TW-1:0] sat;
	logic [CW-1:0] i_next;

	assign slot = IW'(id_q);
	assign id_ok = 32'(id_q) < NUM_TIMERS;
	assign pend = id_ok && pending_q[slot];
	assign total = {1'b0, prev_q} + {1'b0, rd_q.dlt};
	assign hit = {1'b0, tmo_q} <= total;
	assign i_next = i_q + CW'(1);
	assign stop = (count_q == '0) || (n_q == NRES_W'(MAX_RESULTS)) || (el_q < rd_q.dlt);
	assign sat = (el_q >= rd_q.dlt) ? '0 : rd_q.dlt - el_q;
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	// memory port control and result pushes
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		push = 1'b0;
		push_d = '0;
		unique case (state_q)
			S_DEC: begin
				if (out_free) begin
					if (kind_q == KIND_TICK) begin
						rd_en = 1'b1;
						rd_addr = head_q;
					end else if (kind_q == KIND_START || kind_q == KIND_CANCEL) begin
						if (!id_ok || (kind_q == KIND_CANCEL && !pend)) begin
							push = 1'b1;
							push_d = '{event_res: EV_IGNORED, which_timer: id_q, last: 1'b1};
						end else if (pend) begin
							rd_en = 1'b1;
							rd_addr = slot;
						end
					end
				end
			end
			S_K1: begin
				if (slot != tail_q) begin
					rd_en = 1'b1;
					rd_addr = rd_q.nxt;
				end else if (slot != head_q) begin
					rd_en = 1'b1;
					rd_addr = rd_q.prv;
				end
			end
			S_K2: begin
				wr_en = 1'b1;
				wr_addr = ce_q.nxt;
				wr_data = '{prv: ce_q.prv, nxt: rd_q.nxt, dlt: rd_q.dlt + ce_q.dlt};
				if (slot != head_q) begin
					rd_en = 1'b1;
					rd_addr = ce_q.prv;
				end
			end
			S_K3: begin
				wr_en = 1'b1;
				wr_addr = ce_q.prv;
				wr_data = '{prv: rd_q.prv, nxt: ce_q.nxt, dlt: rd_q.dlt};
			end
			S_CFIN: begin
				if (kind_q != KIND_START && out_free) begin
					push = 1'b1;
					push_d = '{event_res: EV_CANCELLED, which_timer: id_q, last: 1'b1};
				end
			end
			S_INS0: begin
				if (count_q != '0) begin
					rd_en = 1'b1;
					rd_addr = head_q;
				end
			end
			S_IW: begin
				if (hit) begin
					wr_en = 1'b1;
					wr_addr = cur_q;
					wr_data = '{prv: slot, nxt: rd_q.nxt, dlt: rd_q.dlt - (tmo_q - prev_q)};
				end else if (i_next != count_q) begin
					rd_en = 1'b1;
					rd_addr = rd_q.nxt;
				end
			end
			S_INEW: begin
				wr_en = 1'b1;
				wr_addr = slot;
				wr_data = '{prv: pred_q, nxt: cur_q, dlt: dn_q};
			end
			S_IPRED: begin
				wr_en = 1'b1;
				wr_addr = pred_q;
				wr_data = '{prv: pred_e_q.prv, nxt: slot, dlt: pred_e_q.dlt};
			end
			S_ITAIL: begin
				wr_en = 1'b1;
				wr_addr = slot;
				wr_data = '{prv: tail_q, nxt: rd_q.nxt, dlt: tmo_q - prev_q};
			end
			S_IFIN: begin
				if (out_free) begin
					push = 1'b1;
					push_d = '{event_res: EV_STARTED, which_timer: id_q, last: 1'b1};
				end
			end
			S_TEV: begin
				if (out_free) begin
					if (stop) begin
						if (count_q != '0) begin
							wr_en = 1'b1;
							wr_addr = head_q;
							wr_data = '{prv: rd_q.prv, nxt: rd_q.nxt, dlt: sat};
						end
						push = 1'b1;
						if (held_q) begin
							push_d = '{event_res: EV_EXPIRED, which_timer: 4'(held_id_q),
								last: 1'b1};
						end else begin
							push_d = '{event_res: EV_NONE, which_timer: 4'd0, last: 1'b1};
						end
					end else begin
						rd_en = 1'b1;
						rd_addr = rd_q.nxt;
						if (held_q) begin
							push = 1'b1;
							push_d = '{event_res: EV_EXPIRED, which_timer: 4'(held_id_q),
								last: 1'b0};
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// list memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// request payload and walk registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= req.data.kind;
			id_q <= req.data.timer_id;
			tmo_q <= TW'(req.data.timeout);
			el_q <= TW'(req.data.elapsed);
		end
		unique case (state_q)
			S_DEC: begin
				n_q <= '0;
			end
			S_K1: begin
				ce_q <= rd_q;
			end
			S_INS0: begin
				prev_q <= '0;
				i_q <= '0;
				cur_q <= head_q;
			end
			S_IW: begin
				if (hit) begin
					dn_q <= tmo_q - prev_q;
				end else begin
					pred_q <= cur_q;
					pred_e_q <= rd_q;
					prev_q <= total[TW-1:0];
					i_q <= i_next;
					cur_q <= rd_q.nxt;
				end
			end
			S_ITAIL: begin
				pred_q <= tail_q;
			end
			S_TEV: begin
				if (out_free && !stop) begin
					el_q <= el_q - rd_q.dlt;
					n_q <= n_q + NRES_W'(1);
					held_id_q <= head_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and list control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			pending_q <= '0;
			held_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (out_free) begin
						held_q <= 1'b0;
						if (kind_q == KIND_TICK) begin
							state_q <= S_TEV;
						end else if (kind_q == KIND_START || kind_q == KIND_CANCEL) begin
							if (!id_ok || (kind_q == KIND_CANCEL && !pend)) begin
								state_q <= S_IDLE;
							end else if (pend) begin
								state_q <= S_K1;
							end else begin
								state_q <= S_INS0;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_K1: begin
					if (slot != tail_q) begin
						state_q <= S_K2;
					end else if (slot != head_q) begin
						tail_q <= rd_q.prv;
						state_q <= S_K3;
					end else begin
						state_q <= S_CFIN;
					end
				end
				S_K2: begin
					if (slot == head_q) begin
						head_q <= ce_q.nxt;
						state_q <= S_CFIN;
					end else begin
						state_q <= S_K3;
					end
				end
				S_K3: begin
					state_q <= S_CFIN;
				end
				S_CFIN: begin
					if (kind_q == KIND_START || out_free) begin
						count_q <= count_q - CW'(1);
						pending_q[slot] <= 1'b0;
						state_q <= (kind_q == KIND_START) ? S_INS0 : S_IDLE;
					end
				end
				S_INS0: begin
					state_q <= (count_q == '0) ? S_ITAIL : S_IW;
				end
				S_IW: begin
					if (hit) begin
						state_q <= S_INEW;
					end else if (i_next == count_q) begin
						state_q <= S_ITAIL;
					end
				end
				S_INEW: begin
					if (cur_q == head_q) begin
						head_q <= slot;
						state_q <= S_IFIN;
					end else begin
						state_q <= S_IPRED;
					end
				end
				S_IPRED: begin
					state_q <= S_IFIN;
				end
				S_ITAIL: begin
					tail_q <= slot;
					if (count_q == '0) begin
						head_q <= slot;
						state_q <= S_IFIN;
					end else begin
						state_q <= S_IPRED;
					end
				end
				S_IFIN: begin
					if (out_free) begin
						count_q <= count_q + CW'(1);
						pending_q[slot] <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_TEV: begin
					if (out_free) begin
						if (stop) begin
							state_q <= S_IDLE;
						end else begin
							held_q <= 1'b1;
							pending_q[head_q] <= 1'b0;
							head_q <= rd_q.nxt;
							count_q <= count_q - CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_d;
		end
	end

endmodule
